/* rtl/core/assert_macros.svh */
// Assertion macros shared by the bearing unit RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked at every clock edge outside reset
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication outside reset
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

/* rtl/core/gcb_pkg.sv */
`timescale 1ns / 1ps
package gcb_pkg;

  localparam int unsigned Iters = 24;
  localparam int unsigned DW = 34;  // Q30 datapath with headroom
  localparam logic signed [DW-1:0] KQ30 = 34'sd652032874;
  localparam logic signed [DW-1:0] OneQ30 = 34'sd1073741824;
  // Binary angle conversion: (mag*2^31 + 9e8) / 1.8e9 reduces to
  // (mag*2^22 + BangHalf) / BangDiv; BangRecip is floor(2^54 / BangDiv)
  localparam logic [32:0] BangRecip = 33'd5124095576;
  localparam logic [21:0] BangDiv = 22'd3515625;
  localparam logic [21:0] BangHalf = 22'd1757812;

  // Arctangent table, binary angle units
  function automatic logic [31:0] atan_lut(input logic [4:0] i);
    logic [31:0] r;
    begin
      case (i)
        5'd0: r = 32'd536870912;   5'd1: r = 32'd316933406;
        5'd2: r = 32'd167458907;   5'd3: r = 32'd85004756;
        5'd4: r = 32'd42667331;    5'd5: r = 32'd21354465;
        5'd6: r = 32'd10679838;    5'd7: r = 32'd5340245;
        5'd8: r = 32'd2670163;     5'd9: r = 32'd1335087;
        5'd10: r = 32'd667544;     5'd11: r = 32'd333772;
        5'd12: r = 32'd166886;     5'd13: r = 32'd83443;
        5'd14: r = 32'd41722;      5'd15: r = 32'd20861;
        5'd16: r = 32'd10430;      5'd17: r = 32'd5215;
        5'd18: r = 32'd2608;       5'd19: r = 32'd1304;
        5'd20: r = 32'd652;        5'd21: r = 32'd326;
        5'd22: r = 32'd163;        5'd23: r = 32'd81;
        default: r = 32'd0;
      endcase
      return r;
    end
  endfunction

  // Stage payload of the rotation unit
  typedef struct packed {
    logic signed [DW-1:0] x;
    logic signed [DW-1:0] y;
    logic signed [32:0]   z;
    logic [1:0]           quad;
    logic                 zero;
  } rot_t;

endpackage

/* rtl/core/gcb_sincos.sv */
`timescale 1ns / 1ps
// Pipelined rotation CORDIC: an entry stage plus one stage per iteration; the exit is combinational
module gcb_sincos (
  input  logic                         clk_i,
  input  logic                         en_i,
  input  logic [31:0]                  ang_i,
  output logic signed [gcb_pkg::DW-1:0] cos_o,
  output logic signed [gcb_pkg::DW-1:0] sin_o
);
  localparam int unsigned N = gcb_pkg::Iters;

  gcb_pkg::rot_t st_q [N+1];
  logic [1:0]  q_w;
  logic [31:0] rr_w;

  // Remove the quadrant at entry
  assign q_w  = 2'((ang_i + 32'h2000_0000) >> 30);
  assign rr_w = ang_i - {q_w, 30'd0};

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      st_q[0].x    <= gcb_pkg::KQ30;
      st_q[0].y    <= '0;
      st_q[0].z    <= {rr_w[31], rr_w};
      st_q[0].quad <= q_w;
      st_q[0].zero <= (rr_w == 32'd0);
    end
  end

  // Advance one iteration per stage
  for (genvar i = 0; i < N; i++) begin : g_it
    gcb_pkg::rot_t nx_w;
    logic signed [32:0] a_w;
    assign a_w = 33'(gcb_pkg::atan_lut(5'(i)));
    always_comb begin
      nx_w = st_q[i];
      if (st_q[i].z >= 0) begin
        nx_w.x = st_q[i].x - (st_q[i].y >>> i);
        nx_w.y = st_q[i].y + (st_q[i].x >>> i);
        nx_w.z = st_q[i].z - a_w;
      end else begin
        nx_w.x = st_q[i].x + (st_q[i].y >>> i);
        nx_w.y = st_q[i].y - (st_q[i].x >>> i);
        nx_w.z = st_q[i].z + a_w;
      end
    end
    always_ff @(posedge clk_i) begin
      if (en_i) st_q[i+1] <= nx_w;
    end
  end

  // Restore the quadrant
  logic signed [gcb_pkg::DW-1:0] x_w, y_w;
  always_comb begin
    x_w = st_q[N].zero ? gcb_pkg::OneQ30 : st_q[N].x;
    y_w = st_q[N].zero ? '0 : st_q[N].y;
    case (st_q[N].quad)
      2'd0: begin cos_o = x_w;  sin_o = y_w;  end
      2'd1: begin cos_o = -y_w; sin_o = x_w;  end
      2'd2: begin cos_o = -x_w; sin_o = -y_w; end
      default: begin cos_o = y_w; sin_o = -x_w; end
    endcase
  end
endmodule

/* rtl/core/gcb_vector.sv */
`timescale 1ns / 1ps
// Pipelined vectoring CORDIC giving atan2(east, north) as binary angle
module gcb_vector (
  input  logic                         clk_i,
  input  logic                         en_i,
  input  logic signed [gcb_pkg::DW-1:0] east_i,
  input  logic signed [gcb_pkg::DW-1:0] north_i,
  input  logic                         same_i,
  output logic [31:0]                  ang_o
);
  localparam int unsigned N = gcb_pkg::Iters;
  localparam int unsigned VW = gcb_pkg::DW + 2;

  typedef struct packed {
    logic signed [VW-1:0] u;
    logic signed [VW-1:0] v;
    logic [31:0] z;
    logic        fixed;  // result settled without iterating
  } vec_t;

  vec_t st_q [N+1];
  vec_t in_w;

  // Remove a half turn and settle the zero-east and same-point cases
  always_comb begin
    in_w.u = VW'(north_i);
    in_w.v = VW'(east_i);
    in_w.z = '0;
    in_w.fixed = 1'b0;
    if (north_i < 0) begin
      in_w.u = -in_w.u;
      in_w.v = -in_w.v;
      in_w.z = 32'h8000_0000;
    end
    if (east_i == '0) in_w.fixed = 1'b1;
    if (same_i) begin
      in_w.fixed = 1'b1;
      in_w.z = '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) st_q[0] <= in_w;
  end

  for (genvar i = 0; i < N; i++) begin : g_it
    vec_t nx_w;
    logic [31:0] a_w;
    assign a_w = gcb_pkg::atan_lut(5'(i));
    always_comb begin
      nx_w = st_q[i];
      if (!st_q[i].fixed) begin
        if (st_q[i].v > 0) begin
          nx_w.u = st_q[i].u + (st_q[i].v >>> i);
          nx_w.v = st_q[i].v - (st_q[i].u >>> i);
          nx_w.z = st_q[i].z + a_w;
        end else begin
          nx_w.u = st_q[i].u - (st_q[i].v >>> i);
          nx_w.v = st_q[i].v + (st_q[i].u >>> i);
          nx_w.z = st_q[i].z - a_w;
        end
      end
    end
    always_ff @(posedge clk_i) begin
      if (en_i) st_q[i+1] <= nx_w;
    end
  end

  assign ang_o = st_q[N].z;
endmodule

/* rtl/core/great_circle_bearing_compass_unit.sv */
`timescale 1ns / 1ps
// Channel  Handshake         Payload
// in       in_valid/ready    start_lat, start_lon, end_lat, end_lon
// out      out_valid/ready   bearing_deg, compass_sector
// One item per cycle while the output is not stalled; the stages run convert,
// sin/cos, products, vectoring and degree/sector in that order.
// The whole pipeline advances together; a stalled output holds every stage.
// rst_ni clears only the valid bits.
module great_circle_bearing_compass_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [30:0] start_lat_i,
  input  logic [31:0] start_lon_i,
  input  logic [30:0] end_lat_i,
  input  logic [31:0] end_lon_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [8:0]  bearing_deg_o,
  output logic [3:0]  compass_sector_o
);
  `include "assert_macros.svh"
  localparam int unsigned DW = gcb_pkg::DW;
  localparam int unsigned Lat = 59;

  logic en;
  logic [Lat-1:0] vld_q;
  assign en = out_ready_i || !vld_q[Lat-1];
  assign in_ready_o = en;
  assign out_valid_o = vld_q[Lat-1];

  // Advance valid bits with the data
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[Lat-2:0], in_valid_i};
    end
  end

  // Stage 1: magnitudes and signs
  logic [31:0] mag_q [4];
  logic [3:0]  neg_q;
  logic        same_q [32];
  always_ff @(posedge clk_i) begin
    if (en) begin
      mag_q[0] <= start_lat_i[30] ? 32'd0 - {1'b1, start_lat_i} : {1'b0, start_lat_i};
      mag_q[1] <= start_lon_i[31] ? 32'(-$signed(start_lon_i)) : start_lon_i;
      mag_q[2] <= end_lat_i[30] ? 32'd0 - {1'b1, end_lat_i} : {1'b0, end_lat_i};
      mag_q[3] <= end_lon_i[31] ? 32'(-$signed(end_lon_i)) : end_lon_i;
      neg_q <= {end_lon_i[31], end_lat_i[30], start_lon_i[31], start_lat_i[30]};
      same_q[0] <= (start_lat_i == end_lat_i) && (start_lon_i == end_lon_i);
    end
  end
  for (genvar k = 1; k < 32; k++) begin : g_same
    always_ff @(posedge clk_i) begin
      if (en) same_q[k] <= same_q[k-1];
    end
  end

  // Stages 2-4: q = (mag*2^22 + 1757812) / 3515625; the reciprocal estimate
  // is low by at most one, so one compare and add finishes it
  logic [53:0] num_q [4];
  logic [63:0] prod_q [4];
  logic [31:0] est_q [4];
  logic [22:0] rem_q [4];
  logic [3:0]  neg2_q, neg3_q;
  logic [31:0] bang_q [4];
  for (genvar k = 0; k < 4; k++) begin : g_cv
    logic [31:0] e_w;
    logic [53:0] ed_w;
    logic [53:0] rem_w;
    logic [31:0] q_w;
    assign e_w = prod_q[k][63:32];
    assign ed_w = 54'(e_w) * 54'(gcb_pkg::BangDiv);
    assign rem_w = num_q[k] - ed_w;
    assign q_w = (rem_q[k] >= 23'(gcb_pkg::BangDiv)) ? est_q[k] + 32'd1 : est_q[k];
    always_ff @(posedge clk_i) begin
      if (en) begin
        num_q[k] <= {mag_q[k], 22'd0} + 54'(gcb_pkg::BangHalf);
        prod_q[k] <= 64'(mag_q[k]) * 64'(gcb_pkg::BangRecip);
        est_q[k] <= e_w;
        rem_q[k] <= rem_w[22:0];
        bang_q[k] <= neg3_q[k] ? 32'd0 - q_w : q_w;
      end
    end
  end
  always_ff @(posedge clk_i) begin
    if (en) begin
      neg2_q <= neg_q;
      neg3_q <= neg2_q;
    end
  end

  // Sine/cosine for both latitudes and the longitude difference
  logic signed [DW-1:0] c1, s1, c2, s2, cd, sd;
  gcb_sincos u_sc1 (.clk_i, .en_i(en), .ang_i(bang_q[0]), .cos_o(c1), .sin_o(s1));
  gcb_sincos u_sc2 (.clk_i, .en_i(en), .ang_i(bang_q[2]), .cos_o(c2), .sin_o(s2));
  gcb_sincos u_scd (.clk_i, .en_i(en), .ang_i(bang_q[3] - bang_q[1]),
                    .cos_o(cd), .sin_o(sd));

  // Products: three multiplies, then the product with cd, then the north difference, each registered
  logic signed [DW-1:0] x_q, y1_q, t_q, y2_q, x2_q, cd_q, y1b_q, xo_q, yo_q;
  logic signed [2*DW-1:0] px_w, py1_w, pt_w, py2_w;
  assign px_w = c2 * sd;
  assign py1_w = c1 * s2;
  assign pt_w = s1 * c2;
  assign py2_w = t_q * cd_q;
  always_ff @(posedge clk_i) begin
    if (en) begin
      x_q <= DW'(px_w >>> 30);
      y1_q <= DW'(py1_w >>> 30);
      t_q <= DW'(pt_w >>> 30);
      cd_q <= cd;
      x2_q <= x_q;
      y1b_q <= y1_q;
      y2_q <= DW'(py2_w >>> 30);
      xo_q <= x2_q;
      yo_q <= y1b_q - y2_q;
    end
  end

  logic [31:0] ang;
  gcb_vector u_vec (.clk_i, .en_i(en), .east_i(xo_q), .north_i(yo_q),
                    .same_i(same_q[31]), .ang_o(ang));

  // Degrees then sector; floor(s / 90) is (s * 2913) >> 18 for s below 1482
  logic [8:0] deg_q, deg2_q;
  logic [3:0] sec_q;
  logic [40:0] dp_w;
  logic [10:0] s4_w;
  logic [22:0] sp_w;
  assign dp_w = 41'(ang) * 41'd360;
  assign s4_w = 11'({deg_q, 2'b00}) + 11'd45;
  assign sp_w = 23'(s4_w) * 23'd2913;
  always_ff @(posedge clk_i) begin
    if (en) begin
      deg_q <= dp_w[40:32];
      deg2_q <= deg_q;
      sec_q <= sp_w[21:18];
    end
  end
  assign bearing_deg_o = deg2_q;
  assign compass_sector_o = sec_q;

  `ASSERT_IMPL(a_range, clk_i, rst_ni, out_valid_o, bearing_deg_o < 9'd360)
  `ASSERT_NEXT(a_hold, clk_i, rst_ni, out_valid_o && !out_ready_i, out_valid_o)
  `ASSERT_IMPL(a_ready, clk_i, rst_ni, !out_valid_o, in_ready_o)
endmodule
